// ===== rtl/core/sjf_ready_queue_scheduler_top_assert.svh =====
// ---------------------------------------------------------------------------
// SJF ready queue scheduler assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ---------------------------------------------------------------------------
`ifndef SJF_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define SJF_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that an expression holds at every clock edge out of reset
`define SJF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("sjf assertion failed");

// Check that a condition implies a consequence in the same cycle
`define SJF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sjf assertion failed");

`else

`define SJF_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SJF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/sjf_pkg.sv =====
// ---------------------------------------------------------------------------
// SJF ready queue scheduler package
// Request and status codes, field widths and stream packing constants.
// ---------------------------------------------------------------------------
package sjf_pkg;

	localparam int MaxThreadsDefault = 16;

	localparam int ReqW    = 3;
	localparam int IdW     = 4;
	localparam int PredW   = 30;
	localparam int StatusW = 2;
	localparam int CountW  = 5;

	// Stream packing
	localparam int InUserW  = ReqW;
	localparam int InDataW  = 40;
	localparam int OutUserW = StatusW + 1;
	localparam int OutDataW = 40;

	typedef enum logic [ReqW-1:0] {
		REQ_CREATE   = 3'd0,
		REQ_YIELD    = 3'd1,
		REQ_BLOCK    = 3'd2,
		REQ_WAKE     = 3'd3,
		REQ_DISPATCH = 3'd4
	} req_type_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

// ===== rtl/core/sjf_ready_queue_scheduler_top.sv =====
// ---------------------------------------------------------------------------
// SJF ready queue scheduler
// Shortest-job-first ready queue with per-thread averaged burst prediction.
// ---------------------------------------------------------------------------
// One request per beat, one result beat per request. A request is taken every
// cycle as long as the result side keeps up; each request passes the input
// register, then the result register. The whole request is done in one pass:
// every queue cell compares its prediction with the new one in parallel and
// the row shifts up for a sorted insert or down for a dispatch, and the
// prediction table is read and written in the same cycle. Ties go after equal
// entries. A full queue drops the insert with status full; a dispatch on an
// empty queue reports status empty. Unknown codes and out-of-range thread ids
// give a zero result carrying only the queue count.
`include "sjf_ready_queue_scheduler_top_assert.svh"

module sjf_ready_queue_scheduler_top #(
	parameter int MAX_THREADS = sjf_pkg::MaxThreadsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [3:0] thread_id, [33:4] burst_ns, [39:34] zero
	input  logic [sjf_pkg::InDataW-1:0]   s_tdata,
	// [2:0] req_type
	input  logic [sjf_pkg::InUserW-1:0]   s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [3:0] dispatched_id, [33:4] new_prediction, [38:34] queue_count, [39] zero
	output logic [sjf_pkg::OutDataW-1:0]  m_tdata,
	// [1:0] status, [2] dispatched_valid
	output logic [sjf_pkg::OutUserW-1:0]  m_tuser
);

	localparam int FillW      = $clog2(MAX_THREADS + 1);
	localparam int TableDepth = (MAX_THREADS < (1 << sjf_pkg::IdW)) ?
	                            MAX_THREADS : (1 << sjf_pkg::IdW);
	localparam int TabIdxW    = $clog2(TableDepth);
	localparam int IdW        = sjf_pkg::IdW;
	localparam int PredW      = sjf_pkg::PredW;

	// Input stage
	logic                    valid_s1;
	sjf_pkg::req_type_t      req_s1;
	logic [IdW-1:0]          tid_s1;
	logic [PredW-1:0]        burst_s1;

	// Result stage
	logic                    valid_s2;
	sjf_pkg::status_t        status_s2;
	logic [IdW-1:0]          did_s2;
	logic                    dvalid_s2;
	logic [PredW-1:0]        pred_s2;
	logic [FillW-1:0]        count_s2;

	// State
	logic [FillW-1:0]        fill_q;
	logic [IdW-1:0]          q_id_q   [MAX_THREADS];
	logic [PredW-1:0]        q_pred_q [MAX_THREADS];
	logic [PredW-1:0]        table_q  [TableDepth];

	logic                    load_s2;
	logic                    fire_s1;
	logic                    is_disp;
	logic                    req_ok;
	logic                    is_insert;
	logic                    full;
	logic                    empty;
	logic                    do_insert;
	logic                    do_pop;
	logic                    do_write;
	logic [TabIdxW-1:0]      tid_idx;
	logic [TabIdxW-1:0]      rd_idx;
	logic [PredW-1:0]        rd_pred;
	logic [PredW:0]          sum;
	logic [PredW-1:0]        avg;
	logic [PredW-1:0]        new_pred;
	logic [MAX_THREADS-1:0]  keep;
	logic [IdW-1:0]          q_id_nxt   [MAX_THREADS];
	logic [PredW-1:0]        q_pred_nxt [MAX_THREADS];
	logic [FillW-1:0]        fill_nxt;
	sjf_pkg::status_t        status_nxt;
	logic [IdW-1:0]          did_nxt;
	logic                    dvalid_nxt;
	logic [PredW-1:0]        pred_nxt;

	// Handshake: result register frees when empty or taken
	assign load_s2  = !valid_s2 || m_tready;
	assign fire_s1  = valid_s1 && load_s2;
	assign s_tready = !valid_s1 || load_s2;

	// Decode the request
	always_comb begin
		is_disp   = (req_s1 == sjf_pkg::REQ_DISPATCH);
		req_ok    = ((req_s1 == sjf_pkg::REQ_CREATE) || (req_s1 == sjf_pkg::REQ_YIELD) ||
		             (req_s1 == sjf_pkg::REQ_BLOCK) || (req_s1 == sjf_pkg::REQ_WAKE)) &&
		            (32'(tid_s1) < MAX_THREADS);
		is_insert = req_ok && (req_s1 != sjf_pkg::REQ_BLOCK);
		full      = (fill_q == FillW'(MAX_THREADS));
		empty     = (fill_q == '0);
		do_insert = fire_s1 && is_insert && !full;
		do_pop    = fire_s1 && is_disp && !empty;
		do_write  = fire_s1 && req_ok && (req_s1 != sjf_pkg::REQ_WAKE);
		tid_idx   = tid_s1[TabIdxW-1:0];
		rd_idx    = is_disp ? q_id_q[0][TabIdxW-1:0] : tid_idx;
		rd_pred   = table_q[rd_idx];
	end

	// Averaged prediction update
	always_comb begin
		sum = {1'b0, rd_pred} + {1'b0, burst_s1};
		avg = (rd_pred == '0) ? burst_s1 : sum[PredW:1];
		unique case (req_s1)
			sjf_pkg::REQ_CREATE: new_pred = '0;
			sjf_pkg::REQ_YIELD,
			sjf_pkg::REQ_BLOCK:  new_pred = avg;
			default:             new_pred = rd_pred;
		endcase
	end

	// Sorted insert and pop over the queue row
	always_comb begin
		for (int k = 0; k < MAX_THREADS; k++) begin
			keep[k] = (FillW'(k) < fill_q) && (q_pred_q[k] <= new_pred);
		end
		for (int k = 0; k < MAX_THREADS; k++) begin
			q_id_nxt[k]   = q_id_q[k];
			q_pred_nxt[k] = q_pred_q[k];
		end
		if (is_disp) begin
			for (int k = 0; k < MAX_THREADS - 1; k++) begin
				q_id_nxt[k]   = q_id_q[k + 1];
				q_pred_nxt[k] = q_pred_q[k + 1];
			end
		end else begin
			if (!keep[0]) begin
				q_id_nxt[0]   = tid_s1;
				q_pred_nxt[0] = new_pred;
			end
			for (int k = 1; k < MAX_THREADS; k++) begin
				if (!keep[k]) begin
					q_id_nxt[k]   = keep[k - 1] ? tid_s1   : q_id_q[k - 1];
					q_pred_nxt[k] = keep[k - 1] ? new_pred : q_pred_q[k - 1];
				end
			end
		end
	end

	// Result fields
	always_comb begin
		fill_nxt   = fill_q;
		status_nxt = sjf_pkg::ST_OK;
		did_nxt    = '0;
		dvalid_nxt = 1'b0;
		pred_nxt   = '0;
		if (is_disp) begin
			if (empty) begin
				status_nxt = sjf_pkg::ST_EMPTY;
			end else begin
				did_nxt    = q_id_q[0];
				dvalid_nxt = 1'b1;
				pred_nxt   = rd_pred;
				fill_nxt   = fill_q - FillW'(1);
			end
		end else if (req_ok) begin
			pred_nxt = new_pred;
			if (is_insert) begin
				if (full) begin
					status_nxt = sjf_pkg::ST_FULL;
				end else begin
					fill_nxt = fill_q + FillW'(1);
				end
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= fire_s1;
			end
			if (do_insert || do_pop) begin
				fill_q <= fill_nxt;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1   <= sjf_pkg::req_type_t'(s_tuser[sjf_pkg::ReqW-1:0]);
			tid_s1   <= s_tdata[IdW-1:0];
			burst_s1 <= s_tdata[IdW +: PredW];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_s2 <= status_nxt;
			did_s2    <= did_nxt;
			dvalid_s2 <= dvalid_nxt;
			pred_s2   <= pred_nxt;
			count_s2  <= fill_nxt;
		end
	end

	// Queue cells
	always_ff @(posedge clk) begin
		if (do_insert || do_pop) begin
			for (int k = 0; k < MAX_THREADS; k++) begin
				q_id_q[k]   <= q_id_nxt[k];
				q_pred_q[k] <= q_pred_nxt[k];
			end
		end
	end

	// Prediction table
	always_ff @(posedge clk) begin
		if (do_write) begin
			table_q[tid_idx] <= new_pred;
		end
	end

	// Pack the result beat
	always_comb begin
		m_tvalid = valid_s2;
		m_tdata  = '0;
		m_tdata[IdW-1:0]            = did_s2;
		m_tdata[IdW +: PredW]       = pred_s2;
		m_tdata[IdW + PredW +: sjf_pkg::CountW] = sjf_pkg::CountW'(count_s2);
		m_tuser  = {dvalid_s2, status_s2};
	end

	// Fill never runs past the queue depth
	`SJF_ASSERT_ALWAYS(a_fill_bound, clk, arst_n, 32'(fill_q) <= MAX_THREADS)
	// Head of the queue is never behind the second entry
	`SJF_ASSERT_IMPLY(a_head_sorted, clk, arst_n, fill_q >= FillW'(2), q_pred_q[0] <= q_pred_q[1])
	// An empty result register never stalls the input side
	`SJF_ASSERT_IMPLY(a_no_stall, clk, arst_n, !m_tvalid, s_tready)
	// A popped thread is reported only with status ok
	`SJF_ASSERT_IMPLY(a_pop_ok, clk, arst_n, m_tvalid && dvalid_s2, status_s2 == sjf_pkg::ST_OK)

endmodule
